>>> rtl/vzc_pkg.sv
// ----------------------------------------------------------------------------
// vzc_pkg: shared types and constants of the varint zigzag codec
// Holds the result kind codes, operation codes, controller states and the
// command and status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package vzc_pkg;

  localparam int CNT_W   = 4;
  localparam int GROUP_W = 7;
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 64;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } state_t;

  typedef struct packed {
    logic enc_load;
    logic enc_emit;
    logic dec_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic enc_last;
  } status_t;

endpackage

>>> rtl/vzc_ctrl.sv
// ----------------------------------------------------------------------------
// vzc_ctrl: codec controller
// Accepts input transfers, starts encodes and decode steps, and paces the
// emission of encoded bytes against the output register.
// ----------------------------------------------------------------------------
module vzc_ctrl
  import vzc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_op,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = status.out_free;
        if (in_tvalid && status.out_free) begin
          if (in_op == OP_DECODE) begin
            cmd.dec_step = 1'b1;
          end else begin
            cmd.enc_load = 1'b1;
            state_nxt    = ST_ENC;
          end
        end
      end
      ST_ENC: begin
        if (status.out_free) begin
          cmd.enc_emit = 1'b1;
          if (status.enc_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/vzc_datapath.sv
// ----------------------------------------------------------------------------
// vzc_datapath: codec datapath
// Holds the encode shift register, the decode accumulator with its group
// count, the zigzag mapping logic and the output register.
// ----------------------------------------------------------------------------
module vzc_datapath
  import vzc_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               signed_mode,
  input  logic [FIELD_W-1:0] value_in,
  input  logic [BYTE_W-1:0]  byte_in,
  input  logic               out_tready,
  output logic               out_tvalid,
  output kind_t              kind,
  output logic [BYTE_W-1:0]  byte_out,
  output logic               last,
  output logic [FIELD_W-1:0] value_out
);

  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_W - 1) / GROUP_W;
  localparam int SHIFT_W    = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] enc_r;
  logic [VALUE_BITS-1:0] enc_nxt;
  logic [CNT_W-1:0]      ecnt_r;
  logic [CNT_W-1:0]      ecnt_nxt;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;
  logic [CNT_W-1:0]      grp_r;
  logic [CNT_W-1:0]      grp_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  kind_t                 kind_r;
  kind_t                 kind_nxt;
  logic [BYTE_W-1:0]     byte_r;
  logic [BYTE_W-1:0]     byte_nxt;
  logic                  last_r;
  logic                  last_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;

  logic [VALUE_BITS-1:0] raw_value;
  logic [VALUE_BITS-1:0] mapped_value;
  logic                  enc_last;
  logic [BYTE_W-1:0]     enc_byte;
  logic [SHIFT_W-1:0]    shamt;
  logic [VALUE_BITS-1:0] placed;
  logic [VALUE_BITS-1:0] merged;
  logic [VALUE_BITS-1:0] decoded;
  logic                  grp_at_max;

  assign raw_value    = value_in[VALUE_BITS-1:0];
  assign mapped_value = signed_mode
                        ? ({raw_value[VALUE_BITS-2:0], 1'b0} ^ {VALUE_BITS{raw_value[VALUE_BITS-1]}})
                        : raw_value;

  assign enc_last = (~|enc_r[VALUE_BITS-1:GROUP_W]) || (ecnt_r == CNT_W'(MAX_GROUPS - 1));
  assign enc_byte = enc_last ? enc_r[BYTE_W-1:0] : {1'b1, enc_r[GROUP_W-1:0]};

  assign shamt      = SHIFT_W'(grp_r) * SHIFT_W'(GROUP_W);
  assign placed     = {{(VALUE_BITS-GROUP_W){1'b0}}, byte_in[GROUP_W-1:0]} << shamt;
  assign merged     = acc_r | placed;
  assign decoded    = signed_mode
                      ? ({1'b0, merged[VALUE_BITS-1:1]} ^ {VALUE_BITS{merged[0]}})
                      : merged;
  assign grp_at_max = (grp_r == CNT_W'(MAX_GROUPS - 1));

  assign status.out_free = !out_valid_r || out_tready;
  assign status.enc_last = enc_last;

  always_comb begin
    enc_nxt       = enc_r;
    ecnt_nxt      = ecnt_r;
    acc_nxt       = acc_r;
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    value_nxt     = value_r;

    if (cmd.enc_load) begin
      enc_nxt  = mapped_value;
      ecnt_nxt = '0;
    end

    if (cmd.enc_emit) begin
      enc_nxt       = enc_r >> GROUP_W;
      ecnt_nxt      = ecnt_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_BYTE;
      byte_nxt      = enc_byte;
      last_nxt      = enc_last;
      value_nxt     = '0;
    end

    if (cmd.dec_step) begin
      if (byte_in[GROUP_W]) begin
        if (grp_at_max) begin
          acc_nxt       = '0;
          grp_nxt       = '0;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ERROR;
          byte_nxt      = '0;
          last_nxt      = 1'b0;
          value_nxt     = '0;
        end else begin
          acc_nxt = merged;
          grp_nxt = grp_r + CNT_W'(1);
        end
      end else begin
        acc_nxt       = '0;
        grp_nxt       = '0;
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_VALUE;
        byte_nxt      = '0;
        last_nxt      = 1'b0;
        value_nxt     = decoded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enc_r   <= enc_nxt;
    ecnt_r  <= ecnt_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    value_r <= value_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign kind       = kind_r;
  assign byte_out   = byte_r;
  assign last       = last_r;
  assign value_out  = FIELD_W'(value_r);

endmodule

>>> rtl/varint_zigzag_codec_unit.sv
// ----------------------------------------------------------------------------
// varint_zigzag_codec_unit: base-128 varint codec with zigzag mapping
// Encodes values into one to ceil(VALUE_BITS/7) bytes and decodes a byte
// stream back into values, with optional zigzag signed mapping.
//
//   channel | direction | tdata (low bit up)          | tuser / tlast
//   --------+-----------+-----------------------------+------------------------
//   in_     | input     | value_in[63:0], byte_in     | operation, signed_mode
//   out_    | output    | byte_out[7:0], value_out    | kind; tlast = last
//
// A decode transfer yields at most one result.
// An encode transfer occupies the block until its last byte is emitted: it
// loads the shift register, then sends one byte per cycle through the output
// register. A stalled output holds the emission in place; no bytes are lost.
// Reset clears the controller, the decode accumulator and the output valid.
// ----------------------------------------------------------------------------
module varint_zigzag_codec_unit
  import vzc_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // value_in[63:0], byte_in[71:64]
  input  logic [1:0]  in_tuser,   // operation[0], signed_mode[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // byte_out[7:0], value_out[71:8]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  cmd_t               cmd;
  status_t            status;
  kind_t              kind;
  logic [BYTE_W-1:0]  byte_out;
  logic [FIELD_W-1:0] value_out;

  vzc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vzc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .signed_mode (in_tuser[1]),
    .value_in    (in_tdata[63:0]),
    .byte_in     (in_tdata[71:64]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .kind        (kind),
    .byte_out    (byte_out),
    .last        (out_tlast),
    .value_out   (value_out)
  );

  assign out_tdata = {value_out, byte_out};
  assign out_tuser = kind;

endmodule

>>> tb/sv/varint_zigzag_codec_unit_test.sv
// ----------------------------------------------------------------------------
// varint_zigzag_codec_unit_test: self-checking bench for the varint codec
// Drives encode and decode transfers into the codec with random gaps on both
// sides, predicts each result from the directed table or its own model of the
// encoder and decode accumulator, and compares each output transfer by field.
// A directed table of corner cases runs first, then random traffic made
// mostly of well-formed byte sequences, with a long output stall once.
// ----------------------------------------------------------------------------
module varint_zigzag_codec_unit_test;
  import vzc_pkg::*;

  localparam int GROUPS_MAX = (FIELD_W + GROUP_W - 1) / GROUP_W;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] code_byte;
    logic              last;
    logic [63:0]       value;
  } codec_result_t;

  typedef struct packed {
    logic              op;
    logic              sgn;
    logic [63:0]       value;
    logic [BYTE_W-1:0] code_byte;
    bit                typed;
    codec_result_t     typed_res;
  } codec_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  logic rx_ready = 1'b0;
  logic hold_off = 1'b0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  logic [63:0]      dec_acc = '0;
  logic [CNT_W-1:0] dec_groups = '0;
  codec_result_t    step_res [GROUPS_MAX];

  codec_item_t   offered_items [$];
  codec_result_t expected_results [$];

  int err_count = 0;
  int accepted_items = 0;
  int n_encodes = 0;
  int n_decode_bytes = 0;
  int n_bytes_out = 0;
  int n_values_out = 0;
  int n_errors_out = 0;

  assign out_tready = rx_ready & ~hold_off;

  always #5 clk = ~clk;

  varint_zigzag_codec_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  function automatic int codec_step(input codec_item_t it);
    logic [63:0] v;
    logic [5:0]  shift;
    int          n;
    n = 0;
    if (it.op == OP_ENCODE) begin
      v = it.value;
      if (it.sgn) begin
        v = {v[62:0], 1'b0} ^ {64{v[63]}};
      end
      while (n < GROUPS_MAX - 1 && v > 64'h7f) begin
        step_res[n] = '{KIND_BYTE, {1'b1, v[6:0]}, 1'b0, 64'd0};
        v = v >> GROUP_W;
        n++;
      end
      step_res[n] = '{KIND_BYTE, v[7:0], 1'b1, 64'd0};
      return n + 1;
    end
    shift = 6'(dec_groups * GROUP_W);
    if (it.code_byte[7]) begin
      if (dec_groups + 1 >= GROUPS_MAX) begin
        dec_acc = '0;
        dec_groups = '0;
        step_res[0] = '{KIND_ERROR, 8'd0, 1'b0, 64'd0};
        return 1;
      end
      dec_acc = dec_acc | (64'(it.code_byte[6:0]) << shift);
      dec_groups = dec_groups + 1'b1;
      return 0;
    end
    v = dec_acc | (64'(it.code_byte) << shift);
    if (it.sgn) begin
      v = (v >> 1) ^ {64{v[0]}};
    end
    dec_acc = '0;
    dec_groups = '0;
    step_res[0] = '{KIND_VALUE, 8'd0, 1'b0, v};
    return 1;
  endfunction

  function automatic codec_item_t row(input logic op, input logic sgn,
                                      input logic [63:0] value,
                                      input logic [7:0] code_byte, input bit typed,
                                      input kind_t kind, input logic [7:0] res_byte,
                                      input logic res_last, input logic [63:0] res_value);
    codec_item_t it;
    it.op = op;
    it.sgn = sgn;
    it.value = value;
    it.code_byte = code_byte;
    it.typed = typed;
    it.typed_res = '{kind, res_byte, res_last, res_value};
    return it;
  endfunction

  task automatic send_item(input codec_item_t it);
    int gap;
    gap = (tx_quiet || hold_off) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_items.push_back(it);
    in_tdata <= {it.code_byte, it.value};
    in_tuser <= {it.sgn, it.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin : watch
    codec_item_t   it;
    codec_result_t got;
    codec_result_t want;
    int            cnt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it = offered_items.pop_front();
        accepted_items++;
        if (it.op == OP_ENCODE) n_encodes++;
        else n_decode_bytes++;
        cnt = codec_step(it);
        if (it.typed) begin
          expected_results.push_back(it.typed_res);
        end else begin
          for (int i = 0; i < cnt; i++) expected_results.push_back(step_res[i]);
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{kind_t'(out_tuser), out_tdata[7:0], out_tlast, out_tdata[71:8]};
        case (got.kind)
          KIND_BYTE:  n_bytes_out++;
          KIND_VALUE: n_values_out++;
          default:    n_errors_out++;
        endcase
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result: kind %0d byte %02h last %0b value %016h",
                     got.kind, got.code_byte, got.last, got.value);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.code_byte !== want.code_byte ||
              got.last !== want.last || got.value !== want.value) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: expected kind %0d byte %02h last %0b value %016h",
                       want.kind, want.code_byte, want.last, want.value);
              $display("          actual   kind %0d byte %02h last %0b value %016h",
                       got.kind, got.code_byte, got.last, got.value);
            end
          end
        end
      end
    end
  end

  initial begin : rx_side
    int d;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      d = rx_quiet ? 0 : $urandom_range(0, 14);
      if (d > 0) begin
        rx_ready <= 1'b0;
        repeat (d) @(posedge clk);
      end
      rx_ready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Once the random traffic is under way, the output is held off long enough
  // for the codec to fill up and push back on its input.
  initial begin : back_pressure
    wait (accepted_items >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("varint_zigzag_codec_unit_test: errors");
    $finish;
  end

  initial begin : main_seq
    codec_item_t dir_rows [$];
    codec_item_t it;
    int          sent;
    int          sel;
    int          seq_len;
    int          w;
    logic [63:0] enc_val;
    logic [7:0]  code;
    logic        sgn;

    dir_rows.push_back(row(OP_DECODE, 1'b0, '1, 8'h00, 1, KIND_VALUE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_DECODE, 1'b1, '1, 8'h01, 1, KIND_VALUE, 8'h00, 1'b0, '1));
    dir_rows.push_back(row(OP_ENCODE, 1'b0, 64'd0, 8'hff, 1, KIND_BYTE, 8'h00, 1'b1, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b0, 64'h7f, 8'h00, 1, KIND_BYTE, 8'h7f, 1'b1, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b0, 64'h80, 8'h55, 0, KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b0, '1, 8'haa, 0, KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b1, '1, 8'hff, 1, KIND_BYTE, 8'h01, 1'b1, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b1, 64'h8000_0000_0000_0000, 8'h00, 0,
                           KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b1, 64'h7fff_ffff_ffff_ffff, 8'h00, 0,
                           KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_DECODE, 1'b0, 64'd0, 8'h81, 0, KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_ENCODE, 1'b0, 64'h1234, 8'hff, 0, KIND_BYTE, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_DECODE, 1'b0, '1, 8'h01, 1, KIND_VALUE, 8'h00, 1'b0, 64'h81));
    for (int i = 0; i < GROUPS_MAX - 1; i++) begin
      dir_rows.push_back(row(OP_DECODE, 1'b0, 64'd0, 8'hff, 0, KIND_BYTE, 8'h00, 1'b0, 64'd0));
    end
    dir_rows.push_back(row(OP_DECODE, 1'b1, 64'd0, 8'hff, 1, KIND_ERROR, 8'h00, 1'b0, 64'd0));
    dir_rows.push_back(row(OP_DECODE, 1'b0, 64'd0, 8'h7f, 1, KIND_VALUE, 8'h00, 1'b0, 64'h7f));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
      sel = $urandom_range(0, 9);
      it.typed = 0;
      it.typed_res = '0;
      if (sel < 4) begin
        enc_val = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) enc_val = enc_val >> $urandom_range(0, 63);
        sgn = 1'($urandom_range(0, 1));
        if (sgn && $urandom_range(0, 1) == 1) enc_val = ~enc_val;
        it.op = OP_ENCODE;
        it.sgn = sgn;
        it.value = enc_val;
        it.code_byte = 8'($urandom_range(0, 255));
        send_item(it);
        sent++;
      end else begin
        // Well-formed values end on a clear top bit; broken runs are either
        // random bytes or too many continuation bytes in a row.
        if (sel < 9) seq_len = $urandom_range(1, GROUPS_MAX);
        else if ($urandom_range(0, 1) == 1) seq_len = $urandom_range(1, 6);
        else seq_len = $urandom_range(GROUPS_MAX, GROUPS_MAX + 2);
        for (int k = 0; k < seq_len; k++) begin
          if (sel < 9) begin
            code = 8'($urandom_range(0, 127));
            if (k < seq_len - 1) code[7] = 1'b1;
          end else if (seq_len >= GROUPS_MAX) begin
            code = 8'($urandom_range(128, 255));
          end else begin
            code = 8'($urandom_range(0, 255));
          end
          it.op = OP_DECODE;
          it.sgn = 1'($urandom_range(0, 1));
          it.value = {$urandom, $urandom};
          it.code_byte = code;
          send_item(it);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (w = 0; w < 20000 && (expected_results.size() != 0 || offered_items.size() != 0);
         w++) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      err_count += expected_results.size();
    end

    $display("Covered %0d transfers in: %0d encodes and %0d decode bytes.",
             accepted_items, n_encodes, n_decode_bytes);
    $display("Checked %0d encoded bytes, %0d decoded values and %0d overlong errors.",
             n_bytes_out, n_values_out, n_errors_out);
    if (err_count == 0) begin
      $display("varint_zigzag_codec_unit_test: clean");
    end else begin
      $display("varint_zigzag_codec_unit_test: errors");
    end
    $finish;
  end

endmodule
